// ===== hdl/trt_pkg.sv =====
// Shared types, constants and codes for the transaction retransmit table.
package trt_pkg;

   // Table geometry
   localparam int SLOTS = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Field widths
   localparam int HANDLE_W = 4;
   localparam int BYTE_W = 8;
   localparam int RETRY_W = 4;
   localparam int PERIOD_W = 24;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 24;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Special handles
   localparam logic [HANDLE_W-1:0] NEW_TXN_HANDLE = 4'd8;
   localparam logic [HANDLE_W-1:0] RETIRED_HANDLE = 4'd9;

   // Limits and reset values
   localparam logic [PERIOD_W-1:0] ELAPSED_MAX = 24'hFFFFFF;
   localparam logic [PERIOD_W-1:0] RETX_PERIOD_RESET = 24'd750000;
   localparam logic [RETRY_W-1:0] MAX_RETRIES_RESET = 4'd10;
   localparam logic [RETRY_W-1:0] RETRY_MAX = 4'd15;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RETX_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRIES = 1'd1;

   // Item modes
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_SERVICE = 2'd1;
   localparam logic [1:0] MODE_REPLY = 2'd2;
   localparam logic [1:0] MODE_REQUEST = 2'd3;

   // Result status
   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_SEND = 2'd1;
   localparam logic [1:0] STATUS_EXPIRED = 2'd2;
   localparam logic [1:0] STATUS_ANSWER = 2'd3;

   // Request handle classes
   localparam logic [1:0] HK_ALLOC = 2'd0;
   localparam logic [1:0] HK_DONE = 2'd1;
   localparam logic [1:0] HK_POLL = 2'd2;
   localparam logic [1:0] HK_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [HANDLE_W-1:0] handle;
      logic [BYTE_W-1:0] node_id;
      logic [BYTE_W-1:0] length;
      logic [BYTE_W-1:0] reply_slot;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [HANDLE_W-1:0] slot;
      logic [BYTE_W-1:0] send_node;
      logic [BYTE_W-1:0] send_length;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] hkind;
      logic reply_hit;
      logic [SLOT_W-1:0] idx;
      logic [BYTE_W-1:0] node;
      logic [BYTE_W-1:0] length;
   } cmd_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] retx_period;
      logic [RETRY_W-1:0] max_retries;
   } cfg_type;

endpackage

// ===== hdl/trt_front.sv =====
// Front end: accepts items and decodes them into table commands.
module trt_front (
   input logic req_valid,
   output logic req_ready,
   input trt_pkg::req_type req_data,
   input logic q_full,
   output logic q_push,
   output trt_pkg::cmd_type q_cmd
);
   import trt_pkg::*;

   logic handle_in_table;
   logic reply_in_table;

   assign req_ready = !q_full;
   assign q_push = req_valid && !q_full;

   assign handle_in_table = 32'(req_data.handle) < SLOTS;
   assign reply_in_table = 32'(req_data.reply_slot) < SLOTS;

   always_comb begin
      q_cmd.op = req_data.mode;
      q_cmd.node = req_data.node_id;
      q_cmd.length = req_data.length;
      q_cmd.reply_hit = reply_in_table;
      // special handles decode ahead of slot numbers
      priority if (req_data.handle == NEW_TXN_HANDLE) begin
         q_cmd.hkind = HK_ALLOC;
      end else if (req_data.handle == RETIRED_HANDLE) begin
         q_cmd.hkind = HK_DONE;
      end else if (handle_in_table) begin
         q_cmd.hkind = HK_POLL;
      end else begin
         q_cmd.hkind = HK_NONE;
      end
      if (req_data.mode == MODE_REPLY) begin
         q_cmd.idx = req_data.reply_slot[SLOT_W-1:0];
      end else begin
         q_cmd.idx = req_data.handle[SLOT_W-1:0];
      end
   end

endmodule

// ===== hdl/trt_queue.sv =====
// Short command queue between the front end and the table engine.
module trt_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input trt_pkg::cmd_type push_cmd,
   output logic full,
   input logic pop,
   output logic valid,
   output trt_pkg::cmd_type head
);
   import trt_pkg::*;

   cmd_type mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = count_ff == QCNT_W'(QDEPTH);
   assign valid = count_ff != '0;
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/trt_back.sv =====
// Table engine: slot state, elapsed timer, round-robin service scan, result register.
module trt_back (
   input logic clock,
   input logic reset,
   input trt_pkg::cfg_type cfg,
   input logic q_valid,
   output logic q_pop,
   input trt_pkg::cmd_type q_cmd,
   output logic rsp_valid,
   input logic rsp_ready,
   output trt_pkg::rsp_type rsp_data
);
   import trt_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic in_flight_ff, in_flight_in;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] done_ff, done_in;
   logic [SLOTS-1:0] tout_ff, tout_in;
   logic [RETRY_W-1:0] retry_ff [SLOTS];
   logic [RETRY_W-1:0] retry_in [SLOTS];
   logic [BYTE_W-1:0] node_ff [SLOTS];
   logic [BYTE_W-1:0] len_ff [SLOTS];
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic load;
   logic can_issue;
   logic wr_en;
   logic free_found;
   logic [SLOT_W-1:0] free_idx;
   logic [SLOT_W-1:0] ptr_next;

   assign can_issue = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign ptr_next = (ptr_ff == SLOT_W'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;

   // lowest unused slot
   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      elapsed_in = elapsed_ff;
      in_flight_in = in_flight_ff;
      used_in = used_ff;
      done_in = done_ff;
      tout_in = tout_ff;
      retry_in = retry_ff;
      rsp_data_in = '0;
      load = 1'b0;
      q_pop = 1'b0;
      wr_en = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && can_issue) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  MODE_TICK: begin
                     load = 1'b1;
                     if (elapsed_ff != ELAPSED_MAX) begin
                        elapsed_in = elapsed_ff + 1'b1;
                     end
                  end
                  MODE_SERVICE: begin
                     if (!(elapsed_ff > cfg.retx_period) && in_flight_ff) begin
                        load = 1'b1;
                     end else begin
                        elapsed_in = '0;
                        cnt_in = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  MODE_REPLY: begin
                     load = 1'b1;
                     in_flight_in = 1'b0;
                     if (q_cmd.reply_hit) begin
                        done_in[q_cmd.idx] = 1'b1;
                        used_in[q_cmd.idx] = 1'b0;
                        retry_in[q_cmd.idx] = '0;
                     end
                  end
                  MODE_REQUEST: begin
                     load = 1'b1;
                     rsp_data_in.status = STATUS_ANSWER;
                     rsp_data_in.slot = NEW_TXN_HANDLE;
                     unique case (q_cmd.hkind)
                        HK_ALLOC: begin
                           if (free_found) begin
                              wr_en = 1'b1;
                              used_in[free_idx] = 1'b1;
                              done_in[free_idx] = 1'b0;
                              tout_in[free_idx] = 1'b0;
                              retry_in[free_idx] = '0;
                              rsp_data_in.slot = HANDLE_W'(free_idx);
                           end
                        end
                        HK_POLL: begin
                           priority if (tout_ff[q_cmd.idx]) begin
                              tout_in[q_cmd.idx] = 1'b0;
                              used_in[q_cmd.idx] = 1'b0;
                           end else if (done_ff[q_cmd.idx]) begin
                              used_in[q_cmd.idx] = 1'b0;
                              rsp_data_in.slot = RETIRED_HANDLE;
                           end else begin
                              rsp_data_in.slot = HANDLE_W'(q_cmd.idx);
                           end
                        end
                        HK_DONE, HK_NONE: begin
                        end
                        default: begin
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (used_ff[ptr_ff] && !done_ff[ptr_ff]) begin
               load = 1'b1;
               state_in = ST_IDLE;
               rsp_data_in.slot = HANDLE_W'(ptr_ff);
               if (retry_ff[ptr_ff] > cfg.max_retries) begin
                  // expire; pointer stays on the slot
                  rsp_data_in.status = STATUS_EXPIRED;
                  used_in[ptr_ff] = 1'b0;
                  done_in[ptr_ff] = 1'b0;
                  tout_in[ptr_ff] = 1'b1;
                  retry_in[ptr_ff] = '0;
               end else begin
                  rsp_data_in.status = STATUS_SEND;
                  rsp_data_in.send_node = node_ff[ptr_ff];
                  rsp_data_in.send_length = len_ff[ptr_ff];
                  if (retry_ff[ptr_ff] != RETRY_MAX) begin
                     retry_in[ptr_ff] = retry_ff[ptr_ff] + 1'b1;
                  end
                  ptr_in = ptr_next;
                  in_flight_in = 1'b1;
               end
            end else begin
               ptr_in = ptr_next;
               if (cnt_ff == SLOT_W'(SLOTS - 1)) begin
                  // went all the way round, nothing open
                  load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff <= '0;
         cnt_ff <= '0;
         elapsed_ff <= '0;
         in_flight_ff <= 1'b0;
         used_ff <= '0;
         done_ff <= '0;
         tout_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            retry_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
         elapsed_ff <= elapsed_in;
         in_flight_ff <= in_flight_in;
         used_ff <= used_in;
         done_ff <= done_in;
         tout_ff <= tout_in;
         rsp_valid_ff <= rsp_valid_in;
         retry_ff <= retry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (wr_en) begin
         node_ff[free_idx] <= q_cmd.node;
         len_ff[free_idx] <= q_cmd.length;
      end
   end

endmodule

// ===== hdl/transaction_retransmit_table.sv =====
// Top level of the transaction retransmit table: register port, front end, queue, engine.
//
// The block tracks up to SLOTS outstanding request/response transactions and
// issues each again until a reply completes it or it runs out of retries.
// Each item gives exactly one result item. Items enter through a front end
// that decodes them into commands and parks them in a two-entry queue, so
// req_ready stays high while the queue has room even when the result side
// stalls. The engine behind the queue retires a tick, reply or request call
// straight from idle. A service scan walks the slot table one slot per cycle
// from the round-robin pointer after a launch step, visiting 1 to SLOTS
// slots; a scan that is skipped (period not yet elapsed with a send in
// flight) stays in idle. A result sits in the rsp_ register until taken;
// the engine starts the next command in the cycle the result is accepted.
// Registers: index 0 is the retransmission period in ticks (24 bits, reset
// 750000); index 1 is the retry limit (4 bits, reset 10). Write them only
// while the block is idle. Node id and length of a slot read as undefined
// until the slot is first allocated.
module transaction_retransmit_table (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input trt_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output trt_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic [trt_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [trt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import trt_pkg::*;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // front end to queue
   logic q_push;
   logic q_full;
   cmd_type push_cmd;

   // queue to engine
   logic q_valid;
   logic q_pop;
   cmd_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         if (csr_index == CSR_RETX_PERIOD) begin
            cfg_in.retx_period = csr_wdata[PERIOD_W-1:0];
         end else if (csr_index == CSR_MAX_RETRIES) begin
            cfg_in.max_retries = csr_wdata[RETRY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retx_period <= RETX_PERIOD_RESET;
         cfg_ff.max_retries <= MAX_RETRIES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode each item into a table command
   trt_front u_front (
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .q_full(q_full),
      .q_push(q_push),
      .q_cmd(push_cmd)
   );

   // decouples intake from the engine
   trt_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_cmd(push_cmd),
      .full(q_full),
      .pop(q_pop),
      .valid(q_valid),
      .head(q_head)
   );

   // slot table, timer, scan and result register
   trt_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_cmd(q_head),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ===== hdl/trt_checker.sv =====
// Port-level checks for the transaction retransmit table, bound to the top level.
module trt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input trt_pkg::req_type req_data,
   input logic rsp_valid,
   input logic rsp_ready,
   input trt_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic [trt_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [trt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import trt_pkg::*;

   // no result can be pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // only a send carries node and length
   a_send_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_SEND |->
      rsp_data.send_node == '0 && rsp_data.send_length == '0)
      else $error("node or length on a non-send result");

   // an empty result names no slot
   a_none_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_NONE |-> rsp_data.slot == '0)
      else $error("slot on an empty result");

   // sends and expiries always name a real slot
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_SEND || rsp_data.status == STATUS_EXPIRED)
      |-> 32'(rsp_data.slot) < SLOTS)
      else $error("send or expiry outside the table");

endmodule

bind transaction_retransmit_table trt_checker u_trt_checker (.*);
